// File: design/ffa_pkg.sv
// shared constants, field widths and result codes for the first-fit allocator
`default_nettype none

package ffa_pkg;

    localparam int DEF_MAX_PROCS  = 32;
    localparam int DEF_ADDR_BITS  = 16;
    localparam int DEF_MAX_MEMORY = 16384;

    localparam int CFG_W  = 17;
    localparam int PROC_W = 5;
    localparam int SIZE_W = 17;
    localparam int IDLE_W = 32;
    localparam int KIND_W = 3;
    localparam int BASE_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVICT  = 3'd0,
        KIND_GRANT  = 3'd1,
        KIND_REFUSE = 3'd2,
        KIND_FREED  = 3'd3,
        KIND_ABSENT = 3'd4
    } kind_t;

endpackage

`default_nettype wire

// File: design/ffa_blk_mem.sv
// block table storage: one write port, one read port with registered data
`default_nettype none

module ffa_blk_mem
    import ffa_pkg::*;
#(
    parameter int DEPTH = 2 * DEF_MAX_PROCS + 1,
    parameter int WIDTH = 2 * DEF_ADDR_BITS + 1
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/first_fit_allocator_with_eviction_top.sv
// first-fit memory allocator with eviction of idle processes, top level
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+---------------------------------------
// request   | in        | start high while busy low  | mode, proc_id, size_required, idle_mask
// result    | out       | result_valid, one cycle    | kind, result_proc, base_address, last
// config    | in        | cfg_we                     | cfg_wdata (max_memory)
//
// answers needing no table walk (absent free, refusal, repeat grant) come in the next cycle
// a table walk reads one block entry per cycle from the block table (one read, one write port)
// a placement walks the table to the first fit; a split also moves each later entry up
// and writes the remainder; a release walks the table to the entry, a merge moves entries down
// each eviction adds an age search, a release walk and a new placement
// after reset and after each config write the table is rebuilt with busy high
// results cannot be stalled: each word is shown for exactly one cycle
`default_nettype none

module first_fit_allocator_with_eviction_top
    import ffa_pkg::*;
#(
    parameter int MAX_PROCS = DEF_MAX_PROCS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              mode,
    input  wire logic [PROC_W-1:0] proc_id,
    input  wire logic [SIZE_W-1:0] size_required,
    input  wire logic [IDLE_W-1:0] idle_mask,
    output logic                   result_valid,
    output logic [KIND_W-1:0]      kind,
    output logic [PROC_W-1:0]      result_proc,
    output logic [BASE_W-1:0]      base_address,
    output logic                   last
);

    // table geometry
    localparam int NBLK = 2 * MAX_PROCS + 1;
    localparam int AW   = $clog2(NBLK);
    localparam int IW   = $clog2(NBLK + 1);
    localparam int PW   = $clog2(MAX_PROCS);
    localparam int RW   = $clog2(MAX_PROCS + 1);
    localparam int EW   = 2 * ADDR_BITS + 1;
    // wide enough for block lengths, sizes and config values
    localparam int LW   = (ADDR_BITS + 1 > SIZE_W) ? ADDR_BITS + 1 : SIZE_W;
    localparam longint TOP_L = longint'(1) << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] LAST_RST = ADDR_BITS'(
        (longint'(DEF_MAX_MEMORY) > TOP_L) ? TOP_L - 1 : longint'(DEF_MAX_MEMORY) - 1);

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] last_addr;
        logic                 free;
    } blk_t;

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_PSCAN  = 10'b0000000100,
        S_SHIFT  = 10'b0000001000,
        S_PWR1   = 10'b0000010000,
        S_PWR2   = 10'b0000100000,
        S_VSRCH  = 10'b0001000000,
        S_RSCAN  = 10'b0010000000,
        S_RMERGE = 10'b0100000000,
        S_RDONE  = 10'b1000000000
    } state_t;

    // control state
    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] max_last_reg;
    logic [IW-1:0]        count_reg, count_next;
    logic [RW-1:0]        age_reg, age_next;
    logic [MAX_PROCS-1:0] valid_reg, valid_next;
    logic [ADDR_BITS-1:0] base_reg [MAX_PROCS];
    logic [ADDR_BITS-1:0] base_next [MAX_PROCS];
    logic [RW-1:0]        rank_reg [MAX_PROCS];
    logic [RW-1:0]        rank_next [MAX_PROCS];

    // request being served
    logic [PW-1:0]        p_reg, p_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [IDLE_W-1:0]    idle_reg, idle_next;
    logic [PW-1:0]        q_reg, q_next;
    logic                 retry_reg, retry_next;

    // table walk and entry moves
    logic [IW-1:0]        ridx_reg, ridx_next;
    logic [IW-1:0]        cidx_reg, cidx_next;
    logic                 chk_reg, chk_next;
    blk_t                 prev_reg, prev_next;
    logic [IW-1:0]        hidx_reg, hidx_next;
    blk_t                 hit_reg, hit_next;
    logic                 split_reg, split_next;
    logic [IW-1:0]        src_reg, src_next;
    logic [IW-1:0]        rem_reg, rem_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pidx_reg, pidx_next;
    logic                 up_reg, up_next;
    logic [1:0]           dk_reg, dk_next;
    logic [RW-1:0]        k_reg, k_next;

    // result word
    logic                 ov_reg, ov_next;
    kind_t                kind_reg, kind_next;
    logic [PROC_W-1:0]    rproc_reg, rproc_next;
    logic [BASE_W-1:0]    obase_reg, obase_next;
    logic                 olast_reg, olast_next;

    // table port
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    blk_t                 mem_wdata;
    logic [AW-1:0]        mem_raddr;
    blk_t                 mem_rdata;

    ffa_blk_mem #(
        .DEPTH (NBLK),
        .WIDTH (EW)
    ) u_blk_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // config value clamped to 1..2^ADDR_BITS, kept as last address
    logic [LW-1:0]        cfg_l;
    logic [ADDR_BITS-1:0] cfg_last;
    assign cfg_l = LW'(cfg_wdata);

    always_comb
    begin
        if (cfg_l == '0)
        begin
            cfg_last = '0;
        end
        else if (longint'(cfg_l) > TOP_L)
        begin
            cfg_last = ADDR_BITS'(TOP_L - 1);
        end
        else
        begin
            cfg_last = ADDR_BITS'(cfg_l - LW'(1));
        end
    end

    // request decode
    logic          req_ok;
    logic [PW-1:0] p_in;
    assign req_ok = 32'(proc_id) < 32'(MAX_PROCS);
    assign p_in   = PW'(proc_id);

    // entry under check
    logic [LW-1:0] rd_len;
    logic [LW-1:0] size_l;
    logic          place_hit;
    logic          rel_hit;
    assign rd_len    = LW'(mem_rdata.last_addr) - LW'(mem_rdata.start) + LW'(1);
    assign size_l    = LW'(size_reg);
    assign place_hit = chk_reg && mem_rdata.free && (rd_len >= size_l);
    assign rel_hit   = chk_reg && !mem_rdata.free && (mem_rdata.start == base_reg[q_reg]);

    // placement split points
    logic [ADDR_BITS-1:0] split_start;
    logic [ADDR_BITS-1:0] used_last;
    assign split_start = ADDR_BITS'(LW'(hit_reg.start) + size_l);
    assign used_last   = ADDR_BITS'(LW'(hit_reg.start) + size_l - LW'(1));

    // oldest idle candidate at age position k
    logic [63:0]          idle_ext;
    logic [MAX_PROCS-1:0] cand;
    logic [PW-1:0]        vic;
    assign idle_ext = {32'b0, idle_reg};

    always_comb
    begin
        vic = '0;
        for (int pp = 0; pp < MAX_PROCS; pp++)
        begin
            cand[pp] = valid_reg[pp] && (rank_reg[pp] == k_reg) && idle_ext[pp];
            if (cand[pp])
            begin
                vic = vic | PW'(pp);
            end
        end
    end

    // merge of a released block with its neighbours
    logic          has_next;
    logic          nf;
    logic          pf;
    assign has_next = (hidx_reg + IW'(1)) < count_reg;
    assign nf       = has_next && mem_rdata.free;
    assign pf       = (hidx_reg != '0) && prev_reg.free;

    always_comb
    begin
        logic [IW-1:0] mj;
        logic [1:0]    mk;

        state_next = state_reg;
        count_next = count_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        base_next  = base_reg;
        rank_next  = rank_reg;
        p_next     = p_reg;
        size_next  = size_reg;
        idle_next  = idle_reg;
        q_next     = q_reg;
        retry_next = retry_reg;
        ridx_next  = ridx_reg;
        cidx_next  = cidx_reg;
        chk_next   = chk_reg;
        prev_next  = prev_reg;
        hidx_next  = hidx_reg;
        hit_next   = hit_reg;
        split_next = split_reg;
        src_next   = src_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        up_next    = up_reg;
        dk_next    = dk_reg;
        k_next     = k_reg;
        ov_next    = 1'b0;
        kind_next  = kind_reg;
        rproc_next = rproc_reg;
        obase_next = obase_reg;
        olast_next = olast_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = AW'(ridx_reg);
        mj         = '0;
        mk         = '0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '{start: '0, last_addr: max_last_reg, free: 1'b1};
                count_next = IW'(1);
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    p_next    = p_in;
                    size_next = size_required;
                    idle_next = idle_mask;
                    ridx_next = '0;
                    chk_next  = 1'b0;
                    if (mode)
                    begin
                        if (req_ok && valid_reg[p_in])
                        begin
                            q_next     = p_in;
                            retry_next = 1'b0;
                            state_next = S_RSCAN;
                        end
                        else
                        begin
                            ov_next    = 1'b1;
                            kind_next  = KIND_ABSENT;
                            rproc_next = proc_id;
                            obase_next = '0;
                            olast_next = 1'b1;
                        end
                    end
                    else if (!req_ok || size_required == '0)
                    begin
                        ov_next    = 1'b1;
                        kind_next  = KIND_REFUSE;
                        rproc_next = proc_id;
                        obase_next = '0;
                        olast_next = 1'b1;
                    end
                    else if (valid_reg[p_in])
                    begin
                        ov_next    = 1'b1;
                        kind_next  = KIND_GRANT;
                        rproc_next = proc_id;
                        obase_next = BASE_W'(base_reg[p_in]);
                        olast_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_PSCAN;
                    end
                end
            end

            S_PSCAN:
            begin
                if (place_hit)
                begin
                    hidx_next  = cidx_reg;
                    hit_next   = mem_rdata;
                    split_next = rd_len > size_l;
                    if (rd_len > size_l)
                    begin
                        src_next   = count_reg - IW'(1);
                        rem_next   = count_reg - IW'(1) - cidx_reg;
                        pend_next  = 1'b0;
                        up_next    = 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_PWR2;
                    end
                end
                else if (ridx_reg == count_reg)
                begin
                    k_next     = '0;
                    state_next = S_VSRCH;
                end
                else
                begin
                    chk_next  = 1'b1;
                    cidx_next = ridx_reg;
                    ridx_next = ridx_reg + IW'(1);
                end
            end

            S_SHIFT:
            begin
                mem_raddr = AW'(src_reg);
                if (rem_reg != '0)
                begin
                    pend_next = 1'b1;
                    pidx_next = src_reg;
                    src_next  = up_reg ? src_reg - IW'(1) : src_reg + IW'(1);
                    rem_next  = rem_reg - IW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = up_reg ? AW'(pidx_reg + IW'(1)) : AW'(pidx_reg - IW'(dk_reg));
                    mem_wdata = mem_rdata;
                end
                if (rem_reg == '0 && !pend_reg)
                begin
                    state_next = up_reg ? S_PWR1 : S_RDONE;
                end
            end

            S_PWR1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(hidx_reg + IW'(1));
                mem_wdata  = '{start: split_start, last_addr: hit_reg.last_addr, free: 1'b1};
                count_next = count_reg + IW'(1);
                state_next = S_PWR2;
            end

            S_PWR2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(hidx_reg);
                mem_wdata  = '{start: hit_reg.start,
                               last_addr: split_reg ? used_last : hit_reg.last_addr,
                               free: 1'b0};
                valid_next[p_reg] = 1'b1;
                base_next[p_reg]  = hit_reg.start;
                rank_next[p_reg]  = age_reg;
                age_next          = age_reg + RW'(1);
                ov_next    = 1'b1;
                kind_next  = KIND_GRANT;
                rproc_next = PROC_W'(p_reg);
                obase_next = BASE_W'(hit_reg.start);
                olast_next = 1'b1;
                state_next = S_IDLE;
            end

            S_VSRCH:
            begin
                if (k_reg == age_reg)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_REFUSE;
                    rproc_next = PROC_W'(p_reg);
                    obase_next = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (|cand)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_EVICT;
                    rproc_next = PROC_W'(vic);
                    obase_next = BASE_W'(base_reg[vic]);
                    olast_next = 1'b0;
                    q_next     = vic;
                    retry_next = 1'b1;
                    ridx_next  = '0;
                    chk_next   = 1'b0;
                    state_next = S_RSCAN;
                end
                else
                begin
                    k_next = k_reg + RW'(1);
                end
            end

            S_RSCAN:
            begin
                if (rel_hit)
                begin
                    hidx_next  = cidx_reg;
                    hit_next   = mem_rdata;
                    state_next = S_RMERGE;
                end
                else if (ridx_reg == count_reg)
                begin
                    state_next = S_RDONE;
                end
                else
                begin
                    if (chk_reg)
                    begin
                        prev_next = mem_rdata;
                    end
                    chk_next  = 1'b1;
                    cidx_next = ridx_reg;
                    ridx_next = ridx_reg + IW'(1);
                end
            end

            S_RMERGE:
            begin
                mem_we = 1'b1;
                if (nf && pf)
                begin
                    mem_waddr = AW'(hidx_reg - IW'(1));
                    mem_wdata = '{start: prev_reg.start, last_addr: mem_rdata.last_addr,
                                  free: 1'b1};
                    mj = hidx_reg;
                    mk = 2'd2;
                end
                else if (nf)
                begin
                    mem_waddr = AW'(hidx_reg);
                    mem_wdata = '{start: hit_reg.start, last_addr: mem_rdata.last_addr,
                                  free: 1'b1};
                    mj = hidx_reg + IW'(1);
                    mk = 2'd1;
                end
                else if (pf)
                begin
                    mem_waddr = AW'(hidx_reg - IW'(1));
                    mem_wdata = '{start: prev_reg.start, last_addr: hit_reg.last_addr,
                                  free: 1'b1};
                    mj = hidx_reg;
                    mk = 2'd1;
                end
                else
                begin
                    mem_waddr = AW'(hidx_reg);
                    mem_wdata = '{start: hit_reg.start, last_addr: hit_reg.last_addr,
                                  free: 1'b1};
                end
                if (mk != '0)
                begin
                    src_next   = mj + IW'(mk);
                    rem_next   = count_reg - mj - IW'(mk);
                    pend_next  = 1'b0;
                    up_next    = 1'b0;
                    dk_next    = mk;
                    count_next = count_reg - IW'(mk);
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_RDONE;
                end
            end

            S_RDONE:
            begin
                valid_next[q_reg] = 1'b0;
                for (int pp = 0; pp < MAX_PROCS; pp++)
                begin
                    if (valid_reg[pp] && rank_reg[pp] > rank_reg[q_reg])
                    begin
                        rank_next[pp] = rank_reg[pp] - RW'(1);
                    end
                end
                age_next = age_reg - RW'(1);
                if (retry_reg)
                begin
                    ridx_next  = '0;
                    chk_next   = 1'b0;
                    state_next = S_PSCAN;
                end
                else
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_FREED;
                    rproc_next = PROC_W'(q_reg);
                    obase_next = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            max_last_reg <= LAST_RST;
            count_reg    <= IW'(1);
            age_reg      <= '0;
            valid_reg    <= '0;
            ov_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            // new memory size: rebuild the table, forget every process
            state_reg    <= S_INIT;
            max_last_reg <= cfg_last;
            count_reg    <= IW'(1);
            age_reg      <= '0;
            valid_reg    <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            age_reg   <= age_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        rank_reg  <= rank_next;
        p_reg     <= p_next;
        size_reg  <= size_next;
        idle_reg  <= idle_next;
        q_reg     <= q_next;
        retry_reg <= retry_next;
        ridx_reg  <= ridx_next;
        cidx_reg  <= cidx_next;
        chk_reg   <= chk_next;
        prev_reg  <= prev_next;
        hidx_reg  <= hidx_next;
        hit_reg   <= hit_next;
        split_reg <= split_next;
        src_reg   <= src_next;
        rem_reg   <= rem_next;
        pend_reg  <= pend_next;
        pidx_reg  <= pidx_next;
        up_reg    <= up_next;
        dk_reg    <= dk_next;
        k_reg     <= k_next;
        kind_reg  <= kind_next;
        rproc_reg <= rproc_next;
        obase_reg <= obase_next;
        olast_reg <= olast_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = ov_reg;
    assign kind         = kind_reg;
    assign result_proc  = rproc_reg;
    assign base_address = obase_reg;
    assign last         = olast_reg;

`ifndef NO_ASSERTIONS
    // free blocks never touch, so the table is bounded by the live processes
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg != '0 &&
            32'(count_reg) <= 2 * 32'(age_reg) + 1))
        else $error("block table count out of bounds");

    // age list length follows the allocated slots
    a_age_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_reg) == 32'(age_reg)))
        else $error("age count disagrees with allocated slots");

    // the final word of a request always returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && olast_reg) |-> (state_reg == S_IDLE))
        else $error("final word while still busy");

    // an eviction is followed by the release walk of the victim
    a_evict_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && kind_reg == KIND_EVICT) |-> (!olast_reg && state_reg == S_RSCAN))
        else $error("eviction word without release walk");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for the first-fit allocator with eviction
`default_nettype none

module tb_top;
    import ffa_pkg::*;

    localparam int NPROC    = 32;
    localparam int NBLOCK   = 2 * NPROC + 1;
    localparam int TOP_MEM  = 65536;
    localparam int N_RANDOM = 140;
    localparam int WATCHDOG = 20000;
    // memory sizes walked after the directed part, extremes included
    localparam int unsigned CFG_SIZES [7] = '{0, 1, 3, 200, 65536, 131071, 4096};

    // one result word as seen on the result ports
    typedef struct packed {
        kind_t             kind;
        logic [PROC_W-1:0] rproc;
        logic [BASE_W-1:0] base;
        logic              last;
    } result_word_t;

    // one row of the directed table; check_now set where the answer is typed in
    typedef struct {
        logic              op_free;
        logic [PROC_W-1:0] pid;
        logic [SIZE_W-1:0] size;
        logic [IDLE_W-1:0] idle;
        logic              check_now;
        kind_t             want_kind;
        logic [BASE_W-1:0] want_base;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    logic mode = 1'b0;
    logic [PROC_W-1:0] proc_id = '0;
    logic [SIZE_W-1:0] size_required = '0;
    logic [IDLE_W-1:0] idle_mask = '0;
    logic result_valid;
    logic [KIND_W-1:0] kind;
    logic [PROC_W-1:0] result_proc;
    logic [BASE_W-1:0] base_address;
    logic last;

    always #2 clk = ~clk;

    first_fit_allocator_with_eviction_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .proc_id      (proc_id),
        .size_required(size_required),
        .idle_mask    (idle_mask),
        .result_valid (result_valid),
        .kind         (kind),
        .result_proc  (result_proc),
        .base_address (base_address),
        .last         (last)
    );

    // shadow allocator state
    int unsigned mem_units;
    int unsigned seg_lo [NBLOCK];
    int unsigned seg_hi [NBLOCK];
    bit          seg_open [NBLOCK];
    int unsigned seg_count;
    int unsigned owner_base [NPROC];
    bit          owner_live [NPROC];
    int unsigned lru_list [$];

    result_word_t pending_words [$];
    int  mismatches = 0;
    int  idle_cycles = 0;

    task automatic report_mismatch(input string what);
        begin
            mismatches++;
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic void wipe_memory(input int unsigned units);
        begin
            mem_units = units;
            seg_lo[0] = 0;
            seg_hi[0] = units - 1;
            seg_open[0] = 1'b1;
            seg_count = 1;
            for (int p = 0; p < NPROC; p++)
            begin
                owner_live[p] = 1'b0;
                owner_base[p] = 0;
            end
            lru_list.delete();
        end
    endfunction

    function automatic void remove_seg(input int unsigned i);
        begin
            for (int unsigned j = i; j + 1 < seg_count; j++)
            begin
                seg_lo[j] = seg_lo[j+1];
                seg_hi[j] = seg_hi[j+1];
                seg_open[j] = seg_open[j+1];
            end
            seg_count--;
        end
    endfunction

    // lowest-address fit, remainder split off behind the placed block
    function automatic bit place_first_fit(input int unsigned p, input int unsigned size);
        int unsigned len;
        begin
            for (int unsigned i = 0; i < seg_count; i++)
            begin
                len = seg_hi[i] - seg_lo[i] + 1;
                if (!seg_open[i] || len < size)
                    continue;
                if (len > size)
                begin
                    if (seg_count >= NBLOCK)
                        continue;
                    for (int unsigned j = seg_count; j > i + 1; j--)
                    begin
                        seg_lo[j] = seg_lo[j-1];
                        seg_hi[j] = seg_hi[j-1];
                        seg_open[j] = seg_open[j-1];
                    end
                    seg_lo[i+1] = seg_lo[i] + size;
                    seg_hi[i+1] = seg_hi[i];
                    seg_open[i+1] = 1'b1;
                    seg_count++;
                    seg_hi[i] = seg_lo[i] + size - 1;
                end
                seg_open[i] = 1'b0;
                owner_base[p] = seg_lo[i];
                owner_live[p] = 1'b1;
                if (lru_list.size() < NPROC)
                    lru_list = {lru_list, p};
                return 1'b1;
            end
            return 1'b0;
        end
    endfunction

    // give the block back and merge with free neighbors
    function automatic void release_owner(input int unsigned p);
        begin
            for (int unsigned i = 0; i < seg_count; i++)
            begin
                if (seg_lo[i] != owner_base[p] || seg_open[i])
                    continue;
                seg_open[i] = 1'b1;
                if (i + 1 < seg_count && seg_open[i+1])
                begin
                    seg_hi[i] = seg_hi[i+1];
                    remove_seg(i + 1);
                end
                if (i > 0 && seg_open[i-1])
                begin
                    seg_hi[i-1] = seg_hi[i];
                    remove_seg(i);
                end
                break;
            end
            owner_live[p] = 1'b0;
            foreach (lru_list[k])
                if (lru_list[k] == p)
                begin
                    lru_list.delete(k);
                    break;
                end
        end
    endfunction

    function automatic void push_word(input kind_t k, input int unsigned p,
                                      input int unsigned b);
        result_word_t w;
        begin
            w.kind = k;
            w.rproc = p[PROC_W-1:0];
            w.base = b[BASE_W-1:0];
            w.last = 1'b0;
            pending_words = {pending_words, w};
        end
    endfunction

    // work out every word one request produces and queue them
    function automatic void predict_request(input logic op_free, input int unsigned p,
                                            input int unsigned size,
                                            input logic [IDLE_W-1:0] idle);
        int n;
        int victim;
        begin
            n = 0;
            if (op_free)
            begin
                if (owner_live[p])
                begin
                    release_owner(p);
                    push_word(KIND_FREED, p, 0);
                end
                else
                    push_word(KIND_ABSENT, p, 0);
            end
            else if (size == 0)
                push_word(KIND_REFUSE, p, 0);
            else if (owner_live[p])
                push_word(KIND_GRANT, p, owner_base[p]);
            else
            begin
                forever
                begin
                    if (place_first_fit(p, size))
                    begin
                        push_word(KIND_GRANT, p, owner_base[p]);
                        break;
                    end
                    victim = -1;
                    foreach (lru_list[k])
                        if (idle[lru_list[k]])
                        begin
                            victim = lru_list[k];
                            break;
                        end
                    if (victim < 0 || n >= 31)
                    begin
                        push_word(KIND_REFUSE, p, 0);
                        break;
                    end
                    push_word(KIND_EVICT, victim, owner_base[victim]);
                    n++;
                    release_owner(victim);
                end
            end
            pending_words[$].last = 1'b1;
        end
    endfunction

    // result monitor: compare each strobed word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            result_word_t w;
            if (pending_words.size() == 0)
                report_mismatch($sformatf("unexpected word kind=%0d proc=%0d", kind,
                                          result_proc));
            else
            begin
                w = pending_words.pop_front();
                if (kind !== w.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, w.kind));
                if (result_proc !== w.rproc)
                    report_mismatch($sformatf("proc %0d, want %0d", result_proc, w.rproc));
                if (base_address !== w.base)
                    report_mismatch($sformatf("base %0d, want %0d", base_address, w.base));
                if (last !== w.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, w.last));
            end
        end
    end

    // watchdog: cycles with neither a request nor a word accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one, sometimes none
    task automatic random_gap();
        int unsigned r;
        int unsigned n;
        begin
            r = $urandom_range(0, 9);
            n = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (n != 0)
                start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // present one request at the falling edge and hold it until accepted;
    // start is dropped by the caller's gap or drain
    task automatic send_request(input logic op_free, input logic [PROC_W-1:0] pid,
                                input logic [SIZE_W-1:0] size,
                                input logic [IDLE_W-1:0] idle);
        begin
            mode <= op_free;
            proc_id <= pid;
            size_required <= size;
            idle_mask <= idle;
            start <= 1'b1;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predict_request(op_free, pid, size, idle);
            @(negedge clk);
        end
    endtask

    // wait until every word is in, then for a quiet stretch before a config write
    task automatic drain();
        int guard;
        begin
            start <= 1'b0;
            guard = 0;
            while (pending_words.size() != 0 && guard < 200000)
            begin
                @(negedge clk);
                guard++;
            end
            repeat (200) @(negedge clk);
        end
    endtask

    task automatic write_max_memory(input int unsigned value);
        int unsigned units;
        begin
            cfg_wdata <= value[CFG_W-1:0];
            cfg_we <= 1'b1;
            @(negedge clk);
            cfg_we <= 1'b0;
            units = value[CFG_W-1:0];
            if (units < 1)
                units = 1;
            if (units > TOP_MEM)
                units = TOP_MEM;
            wipe_memory(units);
            @(negedge clk);
        end
    endtask

    // random phase: allocate bursts with random frees, sizes scaled to memory
    task automatic random_phase(input int count);
        int unsigned sz;
        int unsigned r;
        logic [IDLE_W-1:0] idle;
        begin
            for (int i = 0; i < count; i++)
            begin
                random_gap();
                r = $urandom_range(0, 99);
                idle = $urandom();
                if ($urandom_range(0, 3) == 0)
                    idle = '1;
                if (r < 8)
                    sz = (r < 2) ? 0 : $urandom_range(0, 131071);
                else if (r < 12)
                    sz = mem_units;
                else
                    sz = $urandom_range(1, (mem_units / 6) + 1);
                send_request($urandom_range(0, 99) < 30,
                             PROC_W'($urandom_range(0, NPROC - 1)),
                             sz[SIZE_W-1:0], idle);
            end
        end
    endtask

    stim_row_t directed [] = '{
        // after reset: first grant at zero, repeat grant, a refusal, an absent free, more grants
        '{1'b0, 5'd0,  17'd100,    32'h0, 1'b1, KIND_GRANT,  16'd0},
        '{1'b0, 5'd0,  17'd7,      32'h0, 1'b1, KIND_GRANT,  16'd0},
        '{1'b0, 5'd1,  17'd0,      32'h0, 1'b1, KIND_REFUSE, 16'd0},
        '{1'b1, 5'd31, 17'd0,      32'h0, 1'b1, KIND_ABSENT, 16'd0},
        '{1'b0, 5'd31, 17'd200,    32'h0, 1'b1, KIND_GRANT,  16'd100},
        '{1'b0, 5'd2,  17'd16084,  32'h0, 1'b1, KIND_GRANT,  16'd300},
        // memory full: no idle slot means a plain refusal
        '{1'b0, 5'd3,  17'd1,      32'h0, 1'b1, KIND_REFUSE, 16'd0},
        // oldest idle slot is evicted to make room
        '{1'b0, 5'd3,  17'd50,     32'hffffffff, 1'b0, KIND_GRANT, 16'd0},
        '{1'b1, 5'd31, 17'd0,      32'h0, 1'b1, KIND_FREED,  16'd0},
        '{1'b1, 5'd31, 17'd0,      32'h0, 1'b1, KIND_ABSENT, 16'd0},
        // oversized: everything idle is evicted, then refused
        '{1'b0, 5'd4,  17'h1ffff,  32'hffffffff, 1'b0, KIND_REFUSE, 16'd0},
        '{1'b0, 5'd4,  17'd16384,  32'h0, 1'b1, KIND_GRANT,  16'd0},
        '{1'b1, 5'd4,  17'h1ffff,  32'h0, 1'b1, KIND_FREED,  16'd0},
        '{1'b0, 5'd5,  17'd1,      32'h0, 1'b1, KIND_GRANT,  16'd0},
        '{1'b0, 5'd6,  17'd1,      32'h0, 1'b1, KIND_GRANT,  16'd1},
        '{1'b1, 5'd5,  17'd0,      32'h0, 1'b1, KIND_FREED,  16'd0},
        '{1'b1, 5'd6,  17'd0,      32'h0, 1'b1, KIND_FREED,  16'd0}
    };

    initial
    begin
        wipe_memory(16384);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // directed table; the typed answer is checked against the predictor's
        foreach (directed[i])
        begin
            send_request(directed[i].op_free, directed[i].pid, directed[i].size,
                         directed[i].idle);
            if (directed[i].check_now && (pending_words[$].kind != directed[i].want_kind
                || pending_words[$].base != directed[i].want_base))
                report_mismatch($sformatf("directed row %0d predicts kind %0d", i,
                                          pending_words[$].kind));
        end
        random_phase(30);

        // walk through memory sizes, extremes included, with random traffic
        foreach (CFG_SIZES[s])
        begin
            drain();
            write_max_memory(CFG_SIZES[s]);
            random_phase(N_RANDOM / $size(CFG_SIZES));
        end

        drain();
        if (mismatches == 0 && pending_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: first_fit_allocator_with_eviction_top.f
design/ffa_pkg.sv
design/ffa_blk_mem.sv
design/first_fit_allocator_with_eviction_top.sv
verif/tb_top.sv
